/* hdl/sparse_negacyclic_moment_binner_macros.svh */
// assertion macros shared by the moment binner rtl
`ifndef SPARSE_NEGACYCLIC_MOMENT_BINNER_MACROS_SVH
`define SPARSE_NEGACYCLIC_MOMENT_BINNER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SNMB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snmb assertion failed");
`define SNMB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snmb assertion failed");
`else
`define SNMB_ASSERT_IMP(lbl, ante, cons)
`define SNMB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/snmb_pkg.sv */
// types and constants of the moment binner
`default_nettype none
package snmb_pkg;
  localparam int SEQ_LEN    = 128;
  localparam int LAG_AW     = 7;
  localparam int HALF_LEN   = SEQ_LEN / 2;
  localparam int TERMS      = 6;
  localparam int TERM_IW    = 3;
  localparam int PAIRS      = TERMS * (TERMS - 1);
  localparam int SUP_W      = 5;
  localparam int POS_W      = 7;
  localparam int CF_W       = 3;
  localparam int LAG_W      = 8;
  localparam int ENERGY_W   = 12;
  localparam int ENERGY_MAX = 4095;
  localparam int E_LO       = 5;
  localparam int E_HI       = 81;
  localparam int BIN_W      = 5;
  localparam int MOM_W      = 22;
  localparam int MOMENT_HI  = 2000000;
  localparam int MOMENT_LO  = -2000000;
  localparam int CNT_W      = 48;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 17;
  localparam int IN_W       = 64;
  localparam int OUT_W      = 136;

  typedef logic signed [LAG_W-1:0] lag_t;
  typedef logic signed [MOM_W-1:0] mom_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_PAIR_RD, S_PAIR_WR, S_CHK_A, S_CHK_B, S_CHK_C, S_BIN,
    S_SCAN_A, S_SCAN_B, S_MA, S_MAW, S_MB, S_MBW, S_MT, S_MTW, S_SAT,
    S_STAT, S_STAT_W, S_DONE
  } snmb_state_t;

  typedef struct packed {
    logic             vld;
    logic [BIN_W-1:0] bin;
    mom_t             moment;
  } stat_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    mom_t             mn;
    mom_t             mx;
  } stat_rsp_t;

  // out-of-range coefficient codes saturate to -2..2
  function automatic logic signed [CF_W-1:0] clamp_coeff(input logic [CF_W-1:0] raw);
    logic signed [CF_W-1:0] v;
    v = $signed(raw);
    if (v < -3'sd2) return -3'sd2;
    if (v > 3'sd2) return 3'sd2;
    return v;
  endfunction
endpackage
`default_nettype wire

/* hdl/snmb_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module snmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/snmb_bin_stats.sv */
// per-bin count, minimum and maximum kept in a ram with valid bits
`default_nettype none
`include "sparse_negacyclic_moment_binner_macros.svh"
module snmb_bin_stats #(
  parameter int BINS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire snmb_pkg::stat_req_t req,
  output snmb_pkg::stat_rsp_t     rsp
);
  import snmb_pkg::*;
  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SW = CNT_W + 2 * MOM_W;

  logic [BINS-1:0]  vld_r;
  logic             pend_r;
  logic [AW-1:0]    idx_r;
  mom_t             mom_r;
  logic [SW-1:0]    rdata;
  logic [SW-1:0]    wdata;
  logic [CNT_W-1:0] old_cnt, new_cnt;
  mom_t             old_mn, old_mx, new_mn, new_mx;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  mom_t             mn_r, mx_r;

  snmb_ram #(.WIDTH(SW), .DEPTH(BINS), .AW(AW)) u_tab (
    .clk   (clk),
    .we    (pend_r),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (AW'(req.bin)),
    .rdata (rdata)
  );

  // read-modify-write of one entry; untouched entries read as reset values
  always_comb begin
    if (vld_r[idx_r]) begin
      old_cnt = rdata[SW-1 -: CNT_W];
      old_mn  = rdata[2*MOM_W-1 -: MOM_W];
      old_mx  = rdata[MOM_W-1:0];
    end else begin
      old_cnt = '0;
      old_mn  = MOM_W'(MOMENT_HI);
      old_mx  = MOM_W'(MOMENT_LO);
    end
    new_cnt = (&old_cnt) ? old_cnt : old_cnt + CNT_W'(1);
    new_mn  = (mom_r < old_mn) ? mom_r : old_mn;
    new_mx  = (mom_r > old_mx) ? mom_r : old_mx;
    wdata   = {new_cnt, new_mn, new_mx};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pend_r <= req.vld;
      done_r <= pend_r;
      if (pend_r) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.vld) begin
      idx_r <= AW'(req.bin);
      mom_r <= req.moment;
    end
    if (pend_r) begin
      cnt_r <= new_cnt;
      mn_r  <= new_mn;
      mx_r  <= new_mx;
    end
  end

  assign rsp = '{done: done_r, count: cnt_r, mn: mn_r, mx: mx_r};

  `SNMB_ASSERT_NXT(a_req_pend, req.vld, pend_r)
  `SNMB_ASSERT_NXT(a_pend_done, pend_r, done_r && vld_r[idx_r])
  `SNMB_ASSERT_IMP(a_min_le_max, done_r, mn_r <= mx_r)
endmodule
`default_nettype wire

/* hdl/sparse_negacyclic_moment_binner.sv */
// top level: lag and support memories, item sequencer and output register
//
//  channel | ports                       | transaction
//  in      | in_tvalid/in_tready/tdata   | six positions and six coefficients
//  out     | out_tvalid/out_tready/tdata | energy, bin and updated bin statistics
//
// one item at a time; lag ram (one read port) sets the pace
// non-binned item: clears all 128 lags, applies 30 pair updates, checks lags 0 to 64
// binned item: also scans all 128 lags and sums moment terms over n nonzero lags (n <= 30)
// a finished result waits in the output register while the next item is taken
// reset clears control state only; memories need no clearing pass
`default_nettype none
`include "sparse_negacyclic_moment_binner_macros.svh"
module sparse_negacyclic_moment_binner #(
  parameter int BINS = 20
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // position_0..position_5 (7 each), coeff_0..coeff_5 (3 each), zero fill
  input  wire logic [63:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // energy_ok, energy, bin_hit, bin_number, moment, bin_count, bin_min, bin_max, zero fill
  output logic [135:0]      out_tdata
);
  import snmb_pkg::*;

  snmb_state_t state_r, state_nxt;

  logic [POS_W-1:0]        pos_r [TERMS];
  logic signed [CF_W-1:0]  cf_r  [TERMS];
  logic [LAG_AW-1:0]       idx_r;
  logic [TERM_IW-1:0]      ta_r, tb_r;
  logic [TERM_IW:0]        tb_a, tb_b, ta_n4, tb_n4;
  logic                    pair_last;
  logic [LAG_AW-1:0]       paddr_r;
  logic                    psub_r;
  logic signed [5:0]       prod_r;
  lag_t                    v_r;
  logic                    ok_r;
  logic [ENERGY_W-1:0]     energy_r;
  logic [16:0]             esum;
  logic [ENERGY_W-1:0]     ediff;
  logic                    hit_c;
  logic [BIN_W-1:0]        bin_c;
  logic                    hit_r;
  logic [BIN_W-1:0]        bin_r;
  logic [SUP_W-1:0]        sup_cnt_r, ma_r, mb_r;
  logic [LAG_AW-1:0]       l_r, r_r;
  lag_t                    vl_r, vr_r;
  logic [LAG_AW:0]         lr_sum;
  logic [LAG_AW-1:0]       t_addr;
  logic                    neg_c;
  logic signed [PROD_W-1:0] vlr_c;
  logic signed [PROD_W+LAG_W-1:0] term_c;
  logic signed [PROD_W-1:0] p1_r;
  logic signed [ACC_W-1:0] acc_r;
  mom_t                    moment_r;
  logic [CNT_W-1:0]        cnt_r;
  mom_t                    mn_r, mx_r;

  // lag and support ram ports
  logic                    lag_we;
  logic [LAG_AW-1:0]       lag_waddr, lag_raddr;
  lag_t                    lag_wdata, lag_rdata;
  logic                    sup_we;
  logic [SUP_W-1:0]        sup_raddr;
  logic [LAG_AW+LAG_W-1:0] sup_rdata;

  stat_req_t               stat_req;
  stat_rsp_t               stat_rsp;

  // output register
  logic                    out_vld_r;
  logic                    out_ok_r, out_hit_r;
  logic [ENERGY_W-1:0]     out_energy_r;
  logic [BIN_W-1:0]        out_bin_r;
  mom_t                    out_mom_r, out_mn_r, out_mx_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_load;

  snmb_ram #(.WIDTH(LAG_W), .DEPTH(SEQ_LEN), .AW(LAG_AW)) u_lag (
    .clk   (clk),
    .we    (lag_we),
    .waddr (lag_waddr),
    .wdata (lag_wdata),
    .raddr (lag_raddr),
    .rdata (lag_rdata)
  );

  snmb_ram #(.WIDTH(LAG_AW + LAG_W), .DEPTH(PAIRS), .AW(SUP_W)) u_sup (
    .clk   (clk),
    .we    (sup_we),
    .waddr (sup_cnt_r),
    .wdata ({idx_r, lag_rdata}),
    .raddr (sup_raddr),
    .rdata (sup_rdata)
  );

  snmb_bin_stats #(.BINS(BINS)) u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stat_req),
    .rsp   (stat_rsp)
  );

  // next term pair, skipping a term paired with itself
  always_comb begin
    tb_a = {1'b0, tb_r} + (TERM_IW+1)'(1);
    tb_b = (tb_a == {1'b0, ta_r}) ? tb_a + (TERM_IW+1)'(1) : tb_a;
    if (tb_b >= (TERM_IW+1)'(TERMS)) begin
      ta_n4 = {1'b0, ta_r} + (TERM_IW+1)'(1);
      tb_n4 = '0;
    end else begin
      ta_n4 = {1'b0, ta_r};
      tb_n4 = tb_b;
    end
    pair_last = (ta_n4 == (TERM_IW+1)'(TERMS));
  end

  // energy accumulation, binning and third lag index
  always_comb begin
    esum   = 17'(energy_r) + 17'($unsigned(16'(v_r) * 16'(v_r)));
    ediff  = energy_r - ENERGY_W'(E_LO);
    bin_c  = ediff[BIN_W+1:2];
    hit_c  = ok_r && (energy_r >= ENERGY_W'(E_LO)) && (energy_r <= ENERGY_W'(E_HI))
             && (energy_r[1:0] == 2'b01) && (int'(bin_c) < BINS);
    lr_sum = {1'b0, l_r} + {1'b0, r_r};
    t_addr = LAG_AW'(0) - lr_sum[LAG_AW-1:0];
    // quotient of l+r+t by the length is odd
    neg_c  = (lr_sum[LAG_AW-1:0] == '0) ? lr_sum[LAG_AW] : !lr_sum[LAG_AW];
    // moment term products
    vlr_c  = PROD_W'(vl_r) * PROD_W'(vr_r);
    term_c = (PROD_W+LAG_W)'(p1_r) * (PROD_W+LAG_W)'(lag_rdata);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_CLEAR;
      S_CLEAR:   if (idx_r == LAG_AW'(SEQ_LEN - 1)) state_nxt = S_PAIR_RD;
      S_PAIR_RD: state_nxt = S_PAIR_WR;
      S_PAIR_WR: state_nxt = pair_last ? S_CHK_A : S_PAIR_RD;
      S_CHK_A:   state_nxt = S_CHK_B;
      S_CHK_B:   state_nxt = S_CHK_C;
      S_CHK_C:   state_nxt = (idx_r == LAG_AW'(HALF_LEN)) ? S_BIN : S_CHK_A;
      S_BIN:     state_nxt = hit_c ? S_SCAN_A : S_DONE;
      S_SCAN_A:  state_nxt = S_SCAN_B;
      S_SCAN_B:  if (idx_r == LAG_AW'(SEQ_LEN - 1)) state_nxt = S_MA;
                 else state_nxt = S_SCAN_A;
      S_MA:      state_nxt = S_MAW;
      S_MAW:     state_nxt = S_MB;
      S_MB:      state_nxt = S_MBW;
      S_MBW:     state_nxt = S_MT;
      S_MT:      state_nxt = S_MTW;
      S_MTW: begin
        if (mb_r + SUP_W'(1) < sup_cnt_r) state_nxt = S_MB;
        else if (ma_r + SUP_W'(1) < sup_cnt_r) state_nxt = S_MA;
        else state_nxt = S_SAT;
      end
      S_SAT:     state_nxt = S_STAT;
      S_STAT:    state_nxt = S_STAT_W;
      S_STAT_W:  if (stat_rsp.done) state_nxt = S_DONE;
      S_DONE:    if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_tready = (state_r == S_IDLE);
    out_load  = (state_r == S_DONE) && (!out_vld_r || out_tready);
    lag_we    = 1'b0;
    lag_waddr = idx_r;
    lag_wdata = '0;
    lag_raddr = idx_r;
    sup_we    = 1'b0;
    sup_raddr = ma_r;
    stat_req  = '{vld: (state_r == S_STAT), bin: bin_r, moment: moment_r};
    unique case (state_r)
      S_CLEAR:   lag_we = 1'b1;
      S_PAIR_RD: lag_raddr = pos_r[ta_r] - pos_r[tb_r];
      S_PAIR_WR: begin
        lag_we    = 1'b1;
        lag_waddr = paddr_r;
        lag_wdata = psub_r ? lag_rdata - LAG_W'(prod_r) : lag_rdata + LAG_W'(prod_r);
      end
      S_CHK_B:   lag_raddr = LAG_AW'(0) - idx_r;
      S_SCAN_B:  sup_we = (lag_rdata != '0) && (sup_cnt_r < SUP_W'(PAIRS));
      S_MB:      sup_raddr = mb_r;
      S_MT:      lag_raddr = t_addr;
      default:   lag_we = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        for (int k = 0; k < TERMS; k++) begin
          pos_r[k] <= in_tdata[k*POS_W +: POS_W];
          cf_r[k]  <= clamp_coeff(in_tdata[TERMS*POS_W + k*CF_W +: CF_W]);
        end
        idx_r <= '0;
        ta_r  <= '0;
        tb_r  <= TERM_IW'(1);
      end
      S_CLEAR: idx_r <= idx_r + LAG_AW'(1);
      S_PAIR_RD: begin
        paddr_r <= pos_r[ta_r] - pos_r[tb_r];
        psub_r  <= pos_r[ta_r] < pos_r[tb_r];
        prod_r  <= 6'(cf_r[ta_r]) * 6'(cf_r[tb_r]);
      end
      S_PAIR_WR: begin
        ta_r     <= ta_n4[TERM_IW-1:0];
        tb_r     <= tb_n4[TERM_IW-1:0];
        idx_r    <= '0;
        ok_r     <= 1'b1;
        energy_r <= '0;
      end
      S_CHK_B: v_r <= lag_rdata;
      S_CHK_C: begin
        if ((idx_r == '0) || (idx_r == LAG_AW'(HALF_LEN))) begin
          if (v_r != '0) ok_r <= 1'b0;
        end else begin
          if (9'(lag_rdata) != -9'(v_r)) ok_r <= 1'b0;
          energy_r <= (esum > 17'(ENERGY_MAX)) ? ENERGY_W'(ENERGY_MAX) : esum[ENERGY_W-1:0];
        end
        idx_r <= (idx_r == LAG_AW'(HALF_LEN)) ? '0 : idx_r + LAG_AW'(1);
      end
      S_BIN: begin
        hit_r     <= hit_c;
        bin_r     <= hit_c ? bin_c : '0;
        sup_cnt_r <= '0;
        ma_r      <= '0;
        mb_r      <= '0;
        acc_r     <= '0;
      end
      S_SCAN_B: begin
        if (sup_we) sup_cnt_r <= sup_cnt_r + SUP_W'(1);
        idx_r <= idx_r + LAG_AW'(1);
      end
      S_MAW: begin
        l_r  <= sup_rdata[LAG_AW+LAG_W-1 -: LAG_AW];
        vl_r <= sup_rdata[LAG_W-1:0];
      end
      S_MBW: begin
        r_r  <= sup_rdata[LAG_AW+LAG_W-1 -: LAG_AW];
        vr_r <= sup_rdata[LAG_W-1:0];
      end
      S_MT: p1_r <= neg_c ? -vlr_c : vlr_c;
      S_MTW: begin
        acc_r <= acc_r + ACC_W'(term_c);
        if (mb_r + SUP_W'(1) < sup_cnt_r) begin
          mb_r <= mb_r + SUP_W'(1);
        end else begin
          mb_r <= '0;
          ma_r <= ma_r + SUP_W'(1);
        end
      end
      S_SAT: begin
        if (acc_r > ACC_W'(MOMENT_HI)) moment_r <= MOM_W'(MOMENT_HI);
        else if (acc_r < ACC_W'(MOMENT_LO)) moment_r <= MOM_W'(MOMENT_LO);
        else moment_r <= acc_r[MOM_W-1:0];
      end
      S_STAT_W: begin
        cnt_r <= stat_rsp.count;
        mn_r  <= stat_rsp.mn;
        mx_r  <= stat_rsp.mx;
      end
      default: idx_r <= idx_r;
    endcase
  end

  // output register load
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r     <= ok_r;
      out_energy_r <= ok_r ? energy_r : '0;
      out_hit_r    <= hit_r;
      out_bin_r    <= bin_r;
      out_mom_r    <= hit_r ? moment_r : '0;
      out_cnt_r    <= hit_r ? cnt_r : '0;
      out_mn_r     <= hit_r ? mn_r : '0;
      out_mx_r     <= hit_r ? mx_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_mx_r, out_mn_r, out_cnt_r, out_mom_r, out_bin_r,
                       out_hit_r, out_energy_r, out_ok_r};

  `SNMB_ASSERT_NXT(a_accept_clear, in_tvalid && in_tready, state_r == S_CLEAR)
  `SNMB_ASSERT_IMP(a_sup_bound, state_r == S_SCAN_B, sup_cnt_r <= SUP_W'(PAIRS))
  `SNMB_ASSERT_IMP(a_lag0_zero_scan, state_r == S_SCAN_B && idx_r == '0, lag_rdata == '0)
  `SNMB_ASSERT_IMP(a_bin_range, out_vld_r && out_hit_r, int'(out_bin_r) < BINS)
endmodule
`default_nettype wire

/* bench/tb.sv */
// testbench for the sparse negacyclic moment binner
`default_nettype none
module tb;
  import snmb_pkg::*;

  typedef struct packed {
    logic [21:0]      mx;
    logic [21:0]      mn;
    logic [47:0]      count;
    logic [21:0]      moment;
    logic [4:0]       bin;
    logic             hit;
    logic [11:0]      energy;
    logic             ok;
  } binner_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;

  // bin statistics kept by the predictor
  longint unsigned hist_count[20];
  int              hist_min[20];
  int              hist_max[20];
  binner_res_t     pending_results[$];
  int              mismatches;
  int              sent_items;
  int              got_results;
  int              binned_results;
  int              idle_cycles;
  bit              stall_long;

  sparse_negacyclic_moment_binner i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // short gaps mostly, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 4);
  endfunction

  // expected result of one item, updates the bin statistics
  function automatic binner_res_t predict_bins(input logic [63:0] d);
    int          pos[6];
    int          cf[6];
    int          lags[128];
    int          sup[$];
    int          energy;
    int          t;
    int          s;
    longint      mom;
    bit          ok;
    binner_res_t r;
    r = '0;
    for (int a = 0; a < 6; a++) begin
      pos[a] = d[a*7 +: 7];
      cf[a] = $signed(d[42 + a*3 +: 3]);
      if (cf[a] < -2) cf[a] = -2;
      if (cf[a] > 2) cf[a] = 2;
    end
    for (int i = 0; i < 128; i++) lags[i] = 0;
    for (int a = 0; a < 6; a++)
      for (int b = 0; b < 6; b++)
        if (a != b) begin
          if (pos[a] >= pos[b]) lags[pos[a] - pos[b]] += cf[a] * cf[b];
          else lags[128 - (pos[b] - pos[a])] -= cf[a] * cf[b];
        end
    ok = (lags[0] == 0) && (lags[64] == 0);
    energy = 0;
    for (int i = 1; ok && i < 64; i++) begin
      if (lags[128 - i] != -lags[i]) ok = 0;
      else begin
        energy += lags[i] * lags[i];
        if (energy > 4095) energy = 4095;
      end
    end
    if (!ok) energy = 0;
    r.ok = ok;
    r.energy = 12'(energy);
    if (ok && energy >= 5 && energy <= 81 && energy % 4 == 1 && (energy - 5) / 4 < 20) begin
      r.hit = 1;
      r.bin = 5'((energy - 5) / 4);
      for (int i = 0; i < 128; i++) if (lags[i] != 0 && sup.size() < 30) sup.push_back(i);
      mom = 0;
      foreach (sup[a])
        foreach (sup[b]) begin
          t = (256 - sup[a] - sup[b]) % 128;
          if (lags[t] != 0) begin
            s = (((sup[a] + sup[b] + t) / 128) % 2 == 0) ? 1 : -1;
            mom += s * longint'(lags[sup[a]]) * lags[sup[b]] * lags[t];
          end
        end
      if (mom > 2000000) mom = 2000000;
      if (mom < -2000000) mom = -2000000;
      if (hist_count[r.bin] != 48'hFFFF_FFFF_FFFF) hist_count[r.bin]++;
      if (mom < hist_min[r.bin]) hist_min[r.bin] = int'(mom);
      if (mom > hist_max[r.bin]) hist_max[r.bin] = int'(mom);
      r.moment = 22'(mom);
      r.count = 48'(hist_count[r.bin]);
      r.mn = 22'(hist_min[r.bin]);
      r.mx = 22'(hist_max[r.bin]);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // send one transaction after a random gap
  task automatic send_item(input logic [5:0][6:0] p, input logic [5:0][2:0] c);
    logic [63:0] d;
    int g;
    d = {4'b0, c, p};
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_bins(d));
    sent_items++;
  endtask

  // well-formed: distinct positions, zero coefficient on every term past the first nz
  task automatic send_sparse(input int nz);
    logic [5:0][6:0] p;
    logic [5:0][2:0] c;
    bit used[128];
    int v;
    for (int a = 0; a < 6; a++) begin
      do v = $urandom_range(0, 127); while (used[v]);
      used[v] = 1;
      p[a] = 7'(v);
      c[a] = (a < nz) ? ($urandom_range(0, 1) ? 3'd1 : 3'd7) : 3'd0;
      if (a < nz && $urandom_range(0, 4) == 0) c[a] = $urandom_range(0, 1) ? 3'd2 : 3'd6;
    end
    send_item(p, c);
  endtask

  task automatic send_noise();
    send_item(42'({$urandom, $urandom}), 18'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_item('0, '0);
    send_item({6{7'h7f}}, {6{3'd3}});
    send_item({7'd127, 7'd100, 7'd64, 7'd40, 7'd1, 7'd0}, {3'd4, 3'd5, 3'd3, 3'd6, 3'd2, 3'd1});
    send_item({7'd5, 7'd4, 7'd3, 7'd2, 7'd1, 7'd0}, {6{3'd2}});
    send_item({7'd5, 7'd4, 7'd3, 7'd2, 7'd1, 7'd0}, {6{3'd6}});
    send_item({7'd50, 7'd50, 7'd9, 7'd9, 7'd0, 7'd0}, {3'd1, 3'd1, 3'd7, 3'd7, 3'd1, 3'd2});
    send_item({7'h2a, 7'h55, 7'h2a, 7'h55, 7'h2a, 7'h55}, {3'd5, 3'd2, 3'd5, 3'd2, 3'd5, 3'd2});
  endtask

  task automatic test_binned_items();
    send_item({7'd0, 7'd0, 7'd0, 7'd0, 7'd3, 7'd0}, {3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1});
    send_item({7'd0, 7'd0, 7'd0, 7'd7, 7'd2, 7'd0}, {3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1});
    for (int i = 0; i < 12; i++) send_sparse($urandom_range(2, 4));
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 520; i++) begin
      if (i == 260) wait_drained();
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_sparse($urandom_range(2, 6));
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    binner_res_t got;
    binner_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[132:0];
      got_results++;
      if (pending_results.size() == 0) begin
        $display("unexpected result transaction");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit) binned_results++;
        if (got.ok !== want.ok) report_mismatch("energy_ok", got.ok, want.ok);
        if (got.energy !== want.energy) report_mismatch("energy", got.energy, want.energy);
        if (got.hit !== want.hit) report_mismatch("bin_hit", got.hit, want.hit);
        if (got.bin !== want.bin) report_mismatch("bin_number", got.bin, want.bin);
        if (got.moment !== want.moment)
          report_mismatch("moment", $signed(got.moment), $signed(want.moment));
        if (got.count !== want.count) report_mismatch("bin_count", got.count, want.count);
        if (got.mn !== want.mn) report_mismatch("bin_min", $signed(got.mn), $signed(want.mn));
        if (got.mx !== want.mx) report_mismatch("bin_max", $signed(got.mx), $signed(want.mx));
      end
    end
    if ($urandom_range(0, 99) == 0) stall_long <= ~stall_long;
    out_tready <= stall_long ? ($urandom_range(0, 30) == 0) : ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    stall_long = 0;
    mismatches = 0;
    sent_items = 0;
    got_results = 0;
    binned_results = 0;
    idle_cycles = 0;
    for (int i = 0; i < 20; i++) begin
      hist_count[i] = 0;
      hist_min[i] = 2000000;
      hist_max[i] = -2000000;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_binned_items();
    test_random_mix();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("run covered %0d items and %0d results, %0d of them binned",
             sent_items, got_results, binned_results);
    if (mismatches == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

/* sparse_negacyclic_moment_binner.f */
+incdir+hdl
hdl/snmb_pkg.sv
hdl/snmb_ram.sv
hdl/snmb_bin_stats.sv
hdl/sparse_negacyclic_moment_binner.sv
bench/tb.sv
